// ===== src/pds_pkg.sv =====
// Shared widths, constants and types for the PWM speed sensor decode block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pds_pkg;

  localparam int unsigned CH_W      = 2;
  localparam int unsigned FREQ_W    = 16;
  localparam int unsigned DUTY_W    = 15;
  localparam int unsigned PPR_W     = 8;
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned DIR_W     = 2;
  localparam int unsigned REG_IDX_W = 2;
  // freq * 240 fits in 24 bits
  localparam int unsigned NUM_W     = SPEED_W + PPR_W;

  // quotient bits resolved per divider stage
  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned DIV_BITS   = SPEED_W / DIV_STAGES;

  // channel codes
  localparam logic [CH_W-1:0] CH_0       = 2'd0;
  localparam logic [CH_W-1:0] CH_1       = 2'd1;
  localparam logic [CH_W-1:0] CH_2       = 2'd2;
  localparam logic [CH_W-1:0] CH_INVALID = 2'd3;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_PPR_CH0 = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PPR_CH1 = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PPR_CH2 = 2'd2;

  // default pulses per revolution when the register holds zero
  localparam logic [PPR_W-1:0] DEF_PPR_CH0 = 8'd30;
  localparam logic [PPR_W-1:0] DEF_PPR_CH1 = 8'd40;
  localparam logic [PPR_W-1:0] DEF_PPR_CH2 = 8'd89;

  localparam logic [NUM_W-1:0]   RPM_FACTOR = 24'd240;
  localparam logic [DUTY_W-1:0]  DUTY_FULL  = 15'd16384;

  // 1e6 / 64; the other side of the compare carries 16384 / 64 = 256
  localparam int unsigned LHS_W  = 28;
  localparam int unsigned RHS_W  = 24;
  localparam logic [LHS_W-1:0] TIME_K = 28'd15625;

  // pulse time windows, upper bounds exclusive
  localparam logic [RHS_W-1:0] WIN1_LO  = 24'd50;
  localparam logic [RHS_W-1:0] WIN1_END = 24'd71;
  localparam logic [RHS_W-1:0] WIN2_LO  = 24'd102;
  localparam logic [RHS_W-1:0] WIN2_END = 24'd139;

  // direction codes
  localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_WIN1 = 2'd1;
  localparam logic [DIR_W-1:0] DIR_WIN2 = 2'd2;

  typedef struct packed {
    logic valid;
    logic supplied;
  } pds_ctl_t;

endpackage

// ===== src/pds_div.sv =====
// Pipelined restoring divider for the speed path: num / den, saturated to 16 bits.
// Depends on pds_pkg. DIV_STAGES register stages, DIV_BITS quotient bits each.
`timescale 1ns / 1ps

module pds_div import pds_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pds_ctl_t            ctl_i,
  input  logic [NUM_W-1:0]    num_i,
  input  logic [PPR_W-1:0]    den_i,
  output pds_ctl_t            ctl_o,
  output logic [SPEED_W-1:0]  quo_o
);

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [PPR_W:0] div_step(input logic [PPR_W-1:0] rem,
                                              input logic             nb,
                                              input logic [PPR_W-1:0] den);
    logic [PPR_W:0] t;
    logic [PPR_W:0] diff;
    t    = {rem, nb};
    diff = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      div_step = {1'b1, diff[PPR_W-1:0]};
    end else begin
      div_step = {1'b0, t[PPR_W-1:0]};
    end
  endfunction

  pds_ctl_t           ctl_in [DIV_STAGES];
  logic [PPR_W-1:0]   rem_in [DIV_STAGES];
  logic [SPEED_W-1:0] low_in [DIV_STAGES];
  logic [SPEED_W-1:0] quo_in [DIV_STAGES];
  logic [PPR_W-1:0]   den_in [DIV_STAGES];
  logic               sat_in [DIV_STAGES];

  pds_ctl_t           ctl_q  [DIV_STAGES];
  logic [PPR_W-1:0]   rem_d  [DIV_STAGES];
  logic [PPR_W-1:0]   rem_q  [DIV_STAGES];
  logic [SPEED_W-1:0] low_d  [DIV_STAGES];
  logic [SPEED_W-1:0] low_q  [DIV_STAGES];
  logic [SPEED_W-1:0] quo_d  [DIV_STAGES];
  logic [SPEED_W-1:0] quo_q  [DIV_STAGES];
  logic [PPR_W-1:0]   den_q  [DIV_STAGES];
  logic               sat_q  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      // top byte below den means the quotient fits in 16 bits
      assign ctl_in[s] = ctl_i;
      assign rem_in[s] = num_i[NUM_W-1:SPEED_W];
      assign low_in[s] = num_i[SPEED_W-1:0];
      assign quo_in[s] = '0;
      assign den_in[s] = den_i;
      assign sat_in[s] = (num_i[NUM_W-1:SPEED_W] >= den_i);
    end else begin : g_next
      assign ctl_in[s] = ctl_q[s-1];
      assign rem_in[s] = rem_q[s-1];
      assign low_in[s] = low_q[s-1];
      assign quo_in[s] = quo_q[s-1];
      assign den_in[s] = den_q[s-1];
      assign sat_in[s] = sat_q[s-1];
    end

    always_comb begin : p_steps
      logic [PPR_W:0]     st;
      logic [PPR_W-1:0]   r;
      logic [SPEED_W-1:0] l;
      logic [SPEED_W-1:0] q;
      r = rem_in[s];
      l = low_in[s];
      q = quo_in[s];
      for (int j = 0; j < DIV_BITS; j++) begin
        st = div_step(r, l[SPEED_W-1], den_in[s]);
        r  = st[PPR_W-1:0];
        q  = {q[SPEED_W-2:0], st[PPR_W]};
        l  = {l[SPEED_W-2:0], 1'b0};
      end
      rem_d[s] = r;
      low_d[s] = l;
      quo_d[s] = q;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s] <= '0;
      end else begin
        ctl_q[s] <= ctl_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d[s];
      low_q[s] <= low_d[s];
      quo_q[s] <= quo_d[s];
      den_q[s] <= den_in[s];
      sat_q[s] <= sat_in[s];
    end
  end

  assign ctl_o = ctl_q[DIV_STAGES-1];
  assign quo_o = sat_q[DIV_STAGES-1] ? '1 : quo_q[DIV_STAGES-1];

endmodule

// ===== src/pds_dir.sv =====
// Direction decode: pulse time windows checked by cross-multiplied compares.
// Depends on pds_pkg. Its delay matches pds_div so the results line up.
`timescale 1ns / 1ps

module pds_dir import pds_pkg::*; (
  input  logic              clk_i,
  input  logic [FREQ_W-1:0] freq_i,
  input  logic [DUTY_W-1:0] span_i,
  output logic [DIR_W-1:0]  dir_o
);

  localparam int unsigned DLY = DIV_STAGES - 2;

  // stage 1: products
  logic [LHS_W-1:0] lhs_q;
  logic [RHS_W-1:0] w1_lo_q, w1_end_q, w2_lo_q, w2_end_q;
  logic             fzero_q;

  always_ff @(posedge clk_i) begin
    lhs_q    <= LHS_W'(span_i) * TIME_K;
    w1_lo_q  <= RHS_W'(freq_i) * WIN1_LO;
    w1_end_q <= RHS_W'(freq_i) * WIN1_END;
    w2_lo_q  <= RHS_W'(freq_i) * WIN2_LO;
    w2_end_q <= RHS_W'(freq_i) * WIN2_END;
    fzero_q  <= (freq_i == '0);
  end

  // stage 2: window compares; freq*bound scaled by 256
  logic [RHS_W+7:0] lhs_x;
  logic             in1, in2;
  logic [DIR_W-1:0] dir_d;
  logic [DIR_W-1:0] dir_q [DLY+1];

  assign lhs_x = (RHS_W+8)'(lhs_q);
  assign in1   = (lhs_x >= {w1_lo_q, 8'd0}) && (lhs_x < {w1_end_q, 8'd0});
  assign in2   = (lhs_x >= {w2_lo_q, 8'd0}) && (lhs_x < {w2_end_q, 8'd0});

  always_comb begin
    priority if (fzero_q) begin
      dir_d = DIR_NONE;
    end else if (in1) begin
      dir_d = DIR_WIN1;
    end else if (in2) begin
      dir_d = DIR_WIN2;
    end else begin
      dir_d = DIR_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q[0] <= dir_d;
    for (int i = 1; i <= DLY; i++) begin
      dir_q[i] <= dir_q[i-1];
    end
  end

  assign dir_o = dir_q[DLY];

endmodule

// ===== src/pwm_speed_sensor_decode.sv =====
// PWM speed sensor decode, top level. Uses pds_pkg, pds_div and pds_dir.
// done_o pulses once the start transfer has passed the input stage and
// the 4-stage speed divider; throughput one item per cycle, with the
// divider resolving 4 quotient bits per stage. busy is held low and the
// receiver cannot stall. Async active-low reset clears the pipeline valid
// bits and the pulses-per-rev registers; no result is lost or repeated.
`timescale 1ns / 1ps

module pwm_speed_sensor_decode import pds_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request side
  input  logic                 start,
  output logic                 busy,
  input  logic [CH_W-1:0]      channel_i,
  input  logic [FREQ_W-1:0]    pulse_freq_i,
  input  logic [DUTY_W-1:0]    duty_count_i,
  // result side, one-cycle strobe
  output logic                 done_o,
  output logic [SPEED_W-1:0]   speed_o,
  output logic [DIR_W-1:0]     direction_o,
  output logic                 supplied_o,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [PPR_W-1:0]     cfg_data_i
);

  // Every stage advances every cycle, so a new request is always taken.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  logic accept;
  assign accept = start && !busy;

  // ------------------------------------------------------------------
  // Pulses-per-revolution registers; writes to an unused index drop.
  // ------------------------------------------------------------------
  logic [PPR_W-1:0] ppr_ch0_q, ppr_ch1_q, ppr_ch2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_ch0_q <= '0;
      ppr_ch1_q <= '0;
      ppr_ch2_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_PPR_CH0: ppr_ch0_q <= cfg_data_i;
        REG_PPR_CH1: ppr_ch1_q <= cfg_data_i;
        REG_PPR_CH2: ppr_ch2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Input stage: pick the divisor, form freq*240 and the low-time span.
  // ------------------------------------------------------------------
  logic [PPR_W-1:0]  ppr_eff;
  logic [DUTY_W-1:0] duty_clamped;
  logic [DUTY_W-1:0] span;
  logic [NUM_W-1:0]  num;

  always_comb begin
    unique case (channel_i)
      CH_0:    ppr_eff = (ppr_ch0_q == '0) ? DEF_PPR_CH0 : ppr_ch0_q;
      CH_1:    ppr_eff = (ppr_ch1_q == '0) ? DEF_PPR_CH1 : ppr_ch1_q;
      CH_2:    ppr_eff = (ppr_ch2_q == '0) ? DEF_PPR_CH2 : ppr_ch2_q;
      // invalid channel: any nonzero divisor, result is masked later
      default: ppr_eff = DEF_PPR_CH2;
    endcase
  end

  // duty above full scale counts as full scale (zero low time)
  assign duty_clamped = (duty_count_i > DUTY_FULL) ? DUTY_FULL : duty_count_i;
  assign span         = DUTY_FULL - duty_clamped;
  assign num          = NUM_W'(pulse_freq_i) * RPM_FACTOR;

  pds_ctl_t          ctl_a_q;
  logic [NUM_W-1:0]  num_a_q;
  logic [PPR_W-1:0]  ppr_a_q;
  logic [FREQ_W-1:0] freq_a_q;
  logic [DUTY_W-1:0] span_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
    end else begin
      ctl_a_q.valid    <= accept;
      ctl_a_q.supplied <= (channel_i != CH_INVALID);
    end
  end

  always_ff @(posedge clk_i) begin
    num_a_q  <= num;
    ppr_a_q  <= ppr_eff;
    freq_a_q <= pulse_freq_i;
    span_a_q <= span;
  end

  // ------------------------------------------------------------------
  // Speed divider and direction decode run side by side, same latency.
  // ------------------------------------------------------------------
  pds_ctl_t           ctl_out;
  logic [SPEED_W-1:0] quo;
  logic [DIR_W-1:0]   dir;

  pds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_a_q),
    .num_i  (num_a_q),
    .den_i  (ppr_a_q),
    .ctl_o  (ctl_out),
    .quo_o  (quo)
  );

  pds_dir u_dir (
    .clk_i  (clk_i),
    .freq_i (freq_a_q),
    .span_i (span_a_q),
    .dir_o  (dir)
  );

  // Invalid channel reports zero speed, no direction and supplied low.
  assign done_o      = ctl_out.valid;
  assign supplied_o  = ctl_out.supplied;
  assign speed_o     = ctl_out.supplied ? quo : '0;
  assign direction_o = ctl_out.supplied ? dir : DIR_NONE;

endmodule
